>>> rtl/assert_macros.svh
// Assertion macros used by the port-level checker of the watchdog.
// Each macro expects signals named clk and arst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/lpw_pkg.sv
// Shared types and constants of the landmark progress watchdog.
// No dependencies; used by every RTL module of the block.
`default_nettype none

package lpw_pkg;

	localparam int U_W        = 17;
	localparam int MODE_W     = 4;
	localparam int TS_W       = 48;
	localparam int TIMEOUT_W  = 48;
	localparam int HL_W       = 9;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 48'd1000000;

	localparam int LM_LSB      = 0;
	localparam int PROG_LSB    = LM_LSB + U_W;
	localparam int MODE_LSB    = PROG_LSB + U_W;
	localparam int GUARD_BIT   = MODE_LSB + MODE_W;
	localparam int TS_LSB      = GUARD_BIT + 1;
	localparam int IN_TDATA_W  = 88;

	localparam int NP_BIT      = 0;
	localparam int HL_LSB      = 1;
	localparam int TF_BIT      = HL_LSB + HL_W;
	localparam int OUT_TDATA_W = 16;
	localparam int OUT_PAD_W   = OUT_TDATA_W - TF_BIT - 1;

	typedef enum logic [1:0] {
		OP_APPEND     = 2'd0,
		OP_CLEAR      = 2'd1,
		OP_RESET_PROG = 2'd2,
		OP_CHECK      = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WALK,
		ST_EVAL,
		ST_CMP,
		ST_EMIT
	} ctl_state_t;

	typedef struct packed {
		logic latch_in;
		logic exec;
		logic walk_step;
		logic eval;
		logic cmp;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic check_go;
		logic walk_go;
	} dp_sts_t;

endpackage

`default_nettype wire

>>> rtl/lpw_dp.sv
// Datapath of the watchdog: input register, landmark memory, walk index,
// time mark, timeout register and result register. Depends on lpw_pkg.
`default_nettype none

module lpw_dp #(
	parameter int MAX_LANDMARKS = 256,
	parameter int TIME_BITS     = 48
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic [lpw_pkg::IN_TDATA_W-1:0]   in_tdata,
	input  wire logic [1:0]                       in_tuser,
	input  wire logic                             cfg_valid,
	input  wire logic [lpw_pkg::TIMEOUT_W-1:0]    cfg_data,
	input  wire lpw_pkg::dp_cmd_t                 cmd,
	output lpw_pkg::dp_sts_t                      sts,
	output logic [lpw_pkg::OUT_TDATA_W-1:0]       out_tdata
);

	localparam int IDX_W = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
	localparam int CNT_W = $clog2(MAX_LANDMARKS + 1);
	localparam int MI_W  = IDX_W + 1;
	localparam int CMP_W = (TIME_BITS > lpw_pkg::TIMEOUT_W) ? TIME_BITS : lpw_pkg::TIMEOUT_W;

	lpw_pkg::opcode_t                  op_q;
	logic [lpw_pkg::U_W-1:0]           lm_q;
	logic [lpw_pkg::U_W-1:0]           prog_q;
	logic [lpw_pkg::MODE_W-1:0]        mode_q;
	logic                              guard_q;
	logic [TIME_BITS-1:0]              ts_q;

	logic [lpw_pkg::U_W-1:0]           mem_q [MAX_LANDMARKS];
	logic [lpw_pkg::U_W-1:0]           rd_data_q;
	logic [IDX_W-1:0]                  rd_addr;
	logic                              mem_we;

	logic [CNT_W-1:0]                  count_q;
	logic signed [MI_W-1:0]            max_q;
	logic [TIME_BITS-1:0]              mark_q;
	logic [lpw_pkg::MODE_W-1:0]        last_mode_q;
	logic [lpw_pkg::TIMEOUT_W-1:0]     timeout_q;

	logic [CNT_W-1:0]                  idx_q;
	logic signed [MI_W-1:0]            reached_q;
	logic                              advanced_q;
	logic [TIME_BITS-1:0]              elapsed_q;
	logic                              stall_q;
	logic                              full_q;
	logic [lpw_pkg::OUT_TDATA_W-1:0]   out_tdata_q;

	logic                              max_neg;
	logic                              has_room;
	logic                              check_go;
	logic                              advance;
	logic [CNT_W-1:0]                  start_idx;
	logic [CNT_W-1:0]                  idx_inc;
	logic signed [31:0]                max_ext;
	logic [lpw_pkg::HL_W-1:0]          hl;

	assign max_neg   = max_q[MI_W-1];
	assign has_room  = count_q < CNT_W'(MAX_LANDMARKS);
	assign check_go  = (op_q == lpw_pkg::OP_CHECK) && guard_q && (count_q != '0);
	assign advance   = max_neg || advanced_q;
	assign start_idx = max_neg ? '0 : CNT_W'(max_q[IDX_W-1:0]) + CNT_W'(1);
	assign idx_inc   = idx_q + CNT_W'(1);
	assign rd_addr   = cmd.walk_step ? idx_inc[IDX_W-1:0] : start_idx[IDX_W-1:0];
	assign mem_we    = cmd.exec && (op_q == lpw_pkg::OP_APPEND) && has_room;
	assign max_ext   = 32'(max_q);
	assign hl        = max_ext[lpw_pkg::HL_W-1:0];

	assign sts.check_go = check_go;
	assign sts.walk_go  = (idx_q < count_q) && (prog_q >= rd_data_q);
	assign out_tdata    = out_tdata_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[count_q[IDX_W-1:0]] <= lm_q;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			max_q       <= '1;
			mark_q      <= '0;
			last_mode_q <= '0;
			timeout_q   <= lpw_pkg::TIMEOUT_RESET;
		end else begin
			if (cfg_valid) begin
				timeout_q <= cfg_data;
			end
			if (cmd.exec) begin
				case (op_q)
					lpw_pkg::OP_APPEND: begin
						if (has_room) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
					lpw_pkg::OP_CLEAR: begin
						count_q <= '0;
						max_q   <= '1;
					end
					lpw_pkg::OP_RESET_PROG: begin
						max_q  <= '1;
						mark_q <= '0;
					end
					lpw_pkg::OP_CHECK: begin
						if (check_go && (mode_q != last_mode_q)) begin
							last_mode_q <= mode_q;
							mark_q      <= ts_q;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.cmp && advance) begin
				max_q  <= reached_q;
				mark_q <= ts_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			op_q    <= lpw_pkg::opcode_t'(in_tuser);
			lm_q    <= in_tdata[lpw_pkg::LM_LSB +: lpw_pkg::U_W];
			prog_q  <= in_tdata[lpw_pkg::PROG_LSB +: lpw_pkg::U_W];
			mode_q  <= in_tdata[lpw_pkg::MODE_LSB +: lpw_pkg::MODE_W];
			guard_q <= in_tdata[lpw_pkg::GUARD_BIT];
			ts_q    <= TIME_BITS'(in_tdata[lpw_pkg::TS_LSB +: lpw_pkg::TS_W]);
		end
		if (cmd.exec) begin
			idx_q      <= start_idx;
			reached_q  <= max_q;
			advanced_q <= 1'b0;
			stall_q    <= 1'b0;
			full_q     <= (op_q == lpw_pkg::OP_APPEND) && !has_room;
		end
		if (cmd.walk_step) begin
			reached_q  <= $signed({1'b0, idx_q[IDX_W-1:0]});
			idx_q      <= idx_inc;
			advanced_q <= 1'b1;
		end
		if (cmd.eval) begin
			elapsed_q <= ts_q - mark_q;
		end
		if (cmd.cmp) begin
			stall_q <= !advance && (CMP_W'(elapsed_q) >= CMP_W'(timeout_q));
		end
		if (cmd.load_out) begin
			out_tdata_q <= {{lpw_pkg::OUT_PAD_W{1'b0}}, full_q, hl, stall_q};
		end
	end

endmodule

`default_nettype wire

>>> rtl/lpw_ctrl.sv
// Controller state machine of the watchdog: sequences accept, execution,
// table walk, timeout test and result hand-off. Depends on lpw_pkg.
`default_nettype none

module lpw_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire lpw_pkg::dp_sts_t  sts,
	output lpw_pkg::dp_cmd_t       cmd
);

	lpw_pkg::ctl_state_t state_q;
	lpw_pkg::ctl_state_t state_next;
	logic                out_valid_q;
	logic                slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_next = state_q;
		case (state_q)
			lpw_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_next = lpw_pkg::ST_EXEC;
				end
			end
			lpw_pkg::ST_EXEC: begin
				state_next = sts.check_go ? lpw_pkg::ST_WALK : lpw_pkg::ST_EMIT;
			end
			lpw_pkg::ST_WALK: begin
				if (!sts.walk_go) begin
					state_next = lpw_pkg::ST_EVAL;
				end
			end
			lpw_pkg::ST_EVAL: begin
				state_next = lpw_pkg::ST_CMP;
			end
			lpw_pkg::ST_CMP: begin
				state_next = lpw_pkg::ST_EMIT;
			end
			lpw_pkg::ST_EMIT: begin
				if (slot_free) begin
					state_next = lpw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = lpw_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			lpw_pkg::ST_IDLE: begin
				in_ready     = 1'b1;
				cmd.latch_in = in_valid;
			end
			lpw_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
			end
			lpw_pkg::ST_WALK: begin
				cmd.walk_step = sts.walk_go;
			end
			lpw_pkg::ST_EVAL: begin
				cmd.eval = 1'b1;
			end
			lpw_pkg::ST_CMP: begin
				cmd.cmp = 1'b1;
			end
			lpw_pkg::ST_EMIT: begin
				cmd.load_out = slot_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lpw_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/landmark_progress_watchdog_unit.sv
// Top level of the landmark progress watchdog.
// Instantiates lpw_ctrl and lpw_dp; depends on lpw_pkg.
//
// The unit takes one item per input beat and returns one result beat for
// each. Appends, clears, progress resets and checks with the guard low or
// an empty table go from the execute state straight to the emit state;
// other checks first walk the landmark table through a single registered
// memory port at one entry per cycle. A finished result waits in
// the output register while the next item is accepted. The timeout
// register may be written at any cycle while no item is in flight.
`default_nettype none

module landmark_progress_watchdog_unit #(
	parameter int MAX_LANDMARKS = 256,
	parameter int TIME_BITS     = 48
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// landmark value, progress value, mode_code, prev_guarded, timestamp, one pad bit
	input  wire logic [lpw_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// opcode
	input  wire logic [1:0]                       s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// no_progress, highest_landmark, table_full, five pad bits
	output logic [lpw_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [lpw_pkg::TIMEOUT_W-1:0]    cfg_data
);

	lpw_pkg::dp_cmd_t cmd;
	lpw_pkg::dp_sts_t sts;

	assign cfg_ready = 1'b1;

	lpw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lpw_dp #(
		.MAX_LANDMARKS (MAX_LANDMARKS),
		.TIME_BITS     (TIME_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_tdata  (s_axis_tdata),
		.in_tuser  (s_axis_tuser),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_tdata (m_axis_tdata)
	);

endmodule

`default_nettype wire

>>> rtl/lpw_checker.sv
// Port-level checker of the landmark progress watchdog, bound to the top.
// Depends on assert_macros.svh and lpw_pkg.
`default_nettype none
`include "assert_macros.svh"

module lpw_checker #(
	parameter int MAX_LANDMARKS = 256
) (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_axis_tvalid,
	input wire logic                             s_axis_tready,
	input wire logic                             m_axis_tvalid,
	input wire logic                             m_axis_tready,
	input wire logic [lpw_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

	logic out_wait;
	logic in_take;
	logic out_stall;
	logic out_full;
	logic out_none;

	assign out_wait  = m_axis_tvalid && !m_axis_tready;
	assign in_take   = s_axis_tvalid && s_axis_tready;
	assign out_stall = m_axis_tvalid && m_axis_tdata[lpw_pkg::NP_BIT];
	assign out_full  = m_axis_tdata[lpw_pkg::TF_BIT];
	assign out_none  = (MAX_LANDMARKS <= 256)
		&& (m_axis_tdata[lpw_pkg::TF_BIT-1:lpw_pkg::HL_LSB] == '1);

	`LPW_ASSERT_NEXT(a_out_hold, out_wait, m_axis_tvalid && $stable(m_axis_tdata), "Beat changed.")

	`LPW_ASSERT_NEXT(a_one_in_flight, in_take, !s_axis_tready, "Input taken again too early.")

	`LPW_ASSERT_NOW(a_flags_exclusive, out_stall, !out_full, "Stall and full table on one beat.")

	`LPW_ASSERT_NOW(a_stall_needs_landmark, out_stall, !out_none, "Stall with no landmark reached.")

endmodule

bind landmark_progress_watchdog_unit lpw_checker #(
	.MAX_LANDMARKS (MAX_LANDMARKS)
) u_lpw_checker (.*);

`default_nettype wire

>>> verif/landmark_progress_watchdog_unit_tb.sv
// Self-checking testbench for landmark_progress_watchdog_unit, with its own predictor of the
// landmark table, the progress walk and the stall timer, and random idling on both streams.
// Depends on lpw_pkg and the RTL of the unit only.
`timescale 1ns / 1ps

module landmark_progress_watchdog_unit_tb;

	localparam int TABLE_DEPTH = 256;
	localparam int QUIET_LIMIT = 4000;

	typedef struct {
		lpw_pkg::opcode_t                op;
		logic [lpw_pkg::U_W-1:0]         lm;
		logic [lpw_pkg::U_W-1:0]         prog;
		logic [lpw_pkg::MODE_W-1:0]      mode;
		logic                            guard;
		logic [lpw_pkg::TS_W-1:0]        ts;
		int unsigned                     gap;
	} wd_item_t;

	typedef struct {
		logic                            stall;
		logic [lpw_pkg::HL_W-1:0]        highest;
		logic                            full;
	} wd_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [lpw_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [lpw_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [lpw_pkg::TIMEOUT_W-1:0] cfg_data = '0;

	wd_item_t pending_items[$];
	wd_result_t expected_results[$];
	logic [lpw_pkg::TIMEOUT_W-1:0] timeout_writes[$];
	wd_item_t on_bus;

	// Predictor state.
	logic [lpw_pkg::U_W-1:0] lm_store [TABLE_DEPTH];
	int lm_count = 0;
	int top_idx = -1;
	logic [lpw_pkg::TS_W-1:0] mark = '0;
	logic [lpw_pkg::MODE_W-1:0] seen_mode = '0;
	logic [lpw_pkg::TIMEOUT_W-1:0] timeout_model = lpw_pkg::TIMEOUT_RESET;

	// Stimulus state.
	logic [lpw_pkg::TS_W-1:0] now = '0;
	logic [lpw_pkg::TIMEOUT_W-1:0] phase_tmo = lpw_pkg::TIMEOUT_RESET;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	int unsigned tx_idle = 0;
	int unsigned rx_hold = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	logic [lpw_pkg::U_W-1:0] pr_steps [6] =
		'{17'd5000, 17'd5000, 17'd40000, 17'd40000, '1, '1};

	landmark_progress_watchdog_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	task automatic predict_watchdog(input wd_item_t it, output wd_result_t res);
		int reached;
		int i;
		logic [lpw_pkg::TS_W-1:0] elapsed;
		res.stall = 1'b0;
		res.full = 1'b0;
		case (it.op)
			lpw_pkg::OP_APPEND: begin
				if (lm_count < TABLE_DEPTH) begin
					lm_store[lm_count] = it.lm;
					lm_count++;
				end else begin
					res.full = 1'b1;
				end
			end
			lpw_pkg::OP_CLEAR: begin
				lm_count = 0;
				top_idx = -1;
			end
			lpw_pkg::OP_RESET_PROG: begin
				top_idx = -1;
				mark = '0;
			end
			default: begin
				if (it.guard && lm_count != 0) begin
					reached = top_idx;
					i = (top_idx < 0) ? 0 : top_idx + 1;
					if (it.mode != seen_mode) begin
						seen_mode = it.mode;
						mark = it.ts;
					end
					while (i < lm_count && it.prog >= lm_store[i]) begin
						reached = i;
						i++;
					end
					if (top_idx < 0 || reached > top_idx) begin
						top_idx = reached;
						mark = it.ts;
					end else begin
						elapsed = it.ts - mark;
						if (elapsed >= timeout_model)
							res.stall = 1'b1;
					end
				end
			end
		endcase
		res.highest = lpw_pkg::HL_W'(top_idx);
	endtask

	// Input side: holds each beat until it is taken and predicts its result on acceptance.
	always @(posedge clk or negedge arst_n) begin : feed
		wd_result_t res;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
			tx_idle <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_watchdog(on_bus, res);
				expected_results.insert(expected_results.size(), res);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_items.size() != 0 && tx_idle >= pending_items[0].gap) begin
					on_bus = pending_items.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {1'b0, on_bus.ts, on_bus.guard, on_bus.mode,
						on_bus.prog, on_bus.lm};
					s_axis_tuser <= on_bus.op;
					tx_idle <= 0;
				end else begin
					s_axis_tvalid <= 1'b0;
					if (pending_items.size() != 0)
						tx_idle <= tx_idle + 1;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : timeout_port
		if (!arst_n) begin
			cfg_valid <= 1'b0;
			cfg_data <= '0;
		end else begin
			if (cfg_valid && cfg_ready)
				timeout_model = cfg_data;
			if (!cfg_valid || cfg_ready) begin
				if (timeout_writes.size() != 0) begin
					cfg_valid <= 1'b1;
					cfg_data <= timeout_writes.pop_front();
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : drain
		int unsigned n;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_hold <= 0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			if ($urandom_range(0, 63) == 0)
				rx_calm <= !rx_calm;
			n = rx_calm ? 0 : $urandom_range(0, 19);
			rx_hold <= n;
			m_axis_tready <= (n == 0);
		end else if (rx_hold != 0) begin
			rx_hold <= rx_hold - 1;
			m_axis_tready <= (rx_hold == 1);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic flag_field(input string what, input logic [lpw_pkg::HL_W-1:0] want,
			input logic [lpw_pkg::HL_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected 'h%0h, actual 'h%0h", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin : compare
		wd_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				$display("%0t: result beat expected none, actual 'h%0h", $time, m_axis_tdata);
			end else begin
				want = expected_results.pop_front();
				flag_field("no_progress", lpw_pkg::HL_W'(want.stall),
					lpw_pkg::HL_W'(m_axis_tdata[lpw_pkg::NP_BIT]));
				flag_field("highest_landmark", want.highest,
					m_axis_tdata[lpw_pkg::HL_LSB +: lpw_pkg::HL_W]);
				flag_field("table_full", lpw_pkg::HL_W'(want.full),
					lpw_pkg::HL_W'(m_axis_tdata[lpw_pkg::TF_BIT]));
			end
		end
	end

	always @(posedge clk) begin : progress_guard
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("landmark_progress_watchdog_unit_tb failed");
			$finish;
		end
	end

	function automatic logic [lpw_pkg::TS_W-1:0] rand48();
		return {16'($urandom), $urandom};
	endfunction

	function automatic logic [lpw_pkg::TS_W-1:0] time_step();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return lpw_pkg::TS_W'($urandom_range(1, 50));
			2: return phase_tmo - 1'b1;
			3: return phase_tmo;
			4: return phase_tmo + 1'b1;
			5: return phase_tmo >> 1;
			6: return rand48();
			default: return lpw_pkg::TS_W'($urandom_range(1, 5000));
		endcase
	endfunction

	task automatic push_item(input lpw_pkg::opcode_t op, input logic [lpw_pkg::U_W-1:0] lm,
			input logic [lpw_pkg::U_W-1:0] prog, input logic [lpw_pkg::MODE_W-1:0] mode,
			input logic guard, input logic [lpw_pkg::TS_W-1:0] ts);
		wd_item_t it;
		it.op = op;
		it.lm = lm;
		it.prog = prog;
		it.mode = mode;
		it.guard = guard;
		it.ts = ts;
		it.gap = tx_calm ? 0 : $urandom_range(0, 19);
		pending_items.insert(pending_items.size(), it);
	endtask

	task automatic push_bare(input lpw_pkg::opcode_t op);
		push_item(op, lpw_pkg::U_W'($urandom), lpw_pkg::U_W'($urandom),
			lpw_pkg::MODE_W'($urandom), 1'($urandom), rand48());
	endtask

	task automatic settle();
		while (pending_items.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	task automatic load_timeout(input logic [lpw_pkg::TIMEOUT_W-1:0] value);
		timeout_writes.insert(timeout_writes.size(), value);
		phase_tmo = value;
		@(negedge clk);
		while (timeout_writes.size() != 0 || cfg_valid)
			@(negedge clk);
	endtask

	task automatic run_directed();
		logic [lpw_pkg::TS_W-1:0] t;
		t = lpw_pkg::TIMEOUT_RESET;
		push_item(lpw_pkg::OP_CHECK, '0, '1, 4'd3, 1'b1, 48'd5);
		push_item(lpw_pkg::OP_APPEND, '0, '1, 4'd9, 1'b1, '1);
		push_item(lpw_pkg::OP_APPEND, 17'h10000, '0, 4'd0, 1'b0, '0);
		push_item(lpw_pkg::OP_APPEND, '1, '1, '1, 1'b1, '1);
		// The last entry breaks the ascending order.
		push_item(lpw_pkg::OP_APPEND, 17'd100, '0, '0, 1'b0, '0);
		push_item(lpw_pkg::OP_CHECK, '0, '1, 4'd3, 1'b0, 48'd7);
		push_item(lpw_pkg::OP_CHECK, '1, '0, 4'd3, 1'b1, 48'd10);
		push_item(lpw_pkg::OP_CHECK, '0, '0, 4'd3, 1'b1, 48'd10 + t - 1'b1);
		push_item(lpw_pkg::OP_CHECK, '0, '0, 4'd3, 1'b1, 48'd10 + t);
		push_item(lpw_pkg::OP_CHECK, '0, '0, 4'd7, 1'b1, 48'd15 + t);
		push_item(lpw_pkg::OP_CHECK, '0, '1, 4'd7, 1'b1, 48'd20 + t);
		push_bare(lpw_pkg::OP_RESET_PROG);
		push_item(lpw_pkg::OP_CHECK, '0, '0, 4'd7, 1'b1, '1);
		// Elapsed time across the wrap of the timer.
		push_item(lpw_pkg::OP_CHECK, '0, '0, 4'd7, 1'b1, 48'd3);
		push_item(lpw_pkg::OP_CHECK, '0, '0, 4'd7, 1'b1, t - 48'd2);
		push_item(lpw_pkg::OP_CHECK, '0, '0, 4'd7, 1'b1, t - 48'd1);
		push_bare(lpw_pkg::OP_CLEAR);
		push_item(lpw_pkg::OP_CHECK, '0, '1, 4'd15, 1'b1, '1);
		push_item(lpw_pkg::OP_APPEND, '1, '0, '0, 1'b0, '0);
		push_item(lpw_pkg::OP_CHECK, '0, 17'h10000, 4'd15, 1'b1, 48'd100);
		push_item(lpw_pkg::OP_CHECK, '0, 17'h10000, 4'd15, 1'b1, '1);
		push_item(lpw_pkg::OP_CHECK, '0, '1, 4'd15, 1'b1, '0);
		push_bare(lpw_pkg::OP_CLEAR);
	endtask

	task automatic gen_traffic(input int target);
		int made;
		int lv;
		int pr;
		int k;
		logic [lpw_pkg::MODE_W-1:0] mode;
		made = 0;
		mode = lpw_pkg::MODE_W'($urandom);
		while (made < target) begin
			if ($urandom_range(0, 7) == 0)
				tx_calm = !tx_calm;
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 5)) begin
					now = now + time_step();
					push_item(lpw_pkg::opcode_t'($urandom_range(0, 3)),
						lpw_pkg::U_W'($urandom), lpw_pkg::U_W'($urandom),
						lpw_pkg::MODE_W'($urandom), 1'($urandom),
						($urandom_range(0, 1) != 0) ? now : rand48());
					made++;
				end
			end else begin
				case ($urandom_range(0, 3))
					0, 1: push_bare(lpw_pkg::OP_CLEAR);
					2: push_bare(lpw_pkg::OP_RESET_PROG);
					default: ;
				endcase
				made++;
				lv = $urandom_range(0, 2000);
				k = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
				repeat (k) begin
					if ($urandom_range(0, 9) == 0)
						lv = $urandom_range(0, 131071);
					else
						lv = lv + $urandom_range(0, 6000);
					if (lv > 131071)
						lv = 65536;
					push_item(lpw_pkg::OP_APPEND, lpw_pkg::U_W'(lv), lpw_pkg::U_W'($urandom),
						lpw_pkg::MODE_W'($urandom), 1'($urandom), rand48());
					made++;
				end
				pr = 0;
				repeat ($urandom_range(3, 15)) begin
					case ($urandom_range(0, 5))
						0, 1: ;
						2, 3: pr = pr + $urandom_range(1, 3000);
						4: pr = pr + $urandom_range(0, 20000);
						default: pr = ($urandom_range(0, 1) != 0) ? 65536 : 131071;
					endcase
					if (pr > 131071)
						pr = 131071;
					if ($urandom_range(0, 7) == 0)
						mode = lpw_pkg::MODE_W'($urandom);
					if ($urandom_range(0, 19) == 0) begin
						push_bare(lpw_pkg::OP_RESET_PROG);
						pr = 0;
						made++;
					end
					if ($urandom_range(0, 24) == 0) begin
						push_item(lpw_pkg::OP_APPEND, lpw_pkg::U_W'($urandom),
							lpw_pkg::U_W'($urandom), lpw_pkg::MODE_W'($urandom),
							1'($urandom), rand48());
						made++;
					end
					now = now + time_step();
					push_item(lpw_pkg::OP_CHECK, lpw_pkg::U_W'($urandom), lpw_pkg::U_W'(pr),
						mode, ($urandom_range(0, 9) != 0), now);
					made++;
				end
			end
		end
	endtask

	task automatic fill_table();
		int i;
		logic [lpw_pkg::MODE_W-1:0] mode;
		mode = lpw_pkg::MODE_W'($urandom);
		push_bare(lpw_pkg::OP_CLEAR);
		for (i = 0; i < TABLE_DEPTH + 3; i++)
			push_item(lpw_pkg::OP_APPEND, lpw_pkg::U_W'(i * 250 + $urandom_range(0, 200)),
				lpw_pkg::U_W'($urandom), lpw_pkg::MODE_W'($urandom), 1'($urandom),
				rand48());
		foreach (pr_steps[j]) begin
			now = now + time_step();
			push_item(lpw_pkg::OP_CHECK, lpw_pkg::U_W'($urandom), pr_steps[j], mode, 1'b1,
				now);
		end
		push_bare(lpw_pkg::OP_RESET_PROG);
		now = now + time_step();
		push_item(lpw_pkg::OP_CHECK, lpw_pkg::U_W'($urandom), '1, mode, 1'b1, now);
		push_bare(lpw_pkg::OP_APPEND);
		push_bare(lpw_pkg::OP_CLEAR);
	endtask

	initial begin : sequence_main
		logic [lpw_pkg::TIMEOUT_W-1:0] t;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		run_directed();
		settle();
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: t = '0;
				1: t = '1;
				2: t = lpw_pkg::TIMEOUT_W'($urandom_range(1, 2000));
				3: t = lpw_pkg::TIMEOUT_RESET;
				default: t = rand48();
			endcase
			load_timeout(t);
			gen_traffic(275);
			if (ph == 2)
				fill_table();
			settle();
		end
		if (mismatches == 0)
			$display("landmark_progress_watchdog_unit_tb passed");
		else
			$display("landmark_progress_watchdog_unit_tb failed");
		$finish;
	end

endmodule
